/* rtl/bts_pkg.sv */
package bts_pkg;

   // Default sizing of the texture store and the coordinate format.
   localparam int STORE_TEXELS_DEF    = 65536;
   localparam int MAX_DIM_DEF         = 1024;
   localparam int COORD_FRAC_BITS_DEF = 16;

   // Field widths of the request and response beats.
   localparam int KIND_W   = 1;
   localparam int TEXEL_W  = 16;
   localparam int INDEX_W  = 16;
   localparam int COORD_W  = 32;
   localparam int CHAN_W   = 17;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT  = 2'd2;

   // Request kinds and filter modes.
   localparam logic KIND_LOAD      = 1'b0;
   localparam logic KIND_SAMPLE    = 1'b1;
   localparam logic MODE_NEAREST   = 1'b0;
   localparam logic MODE_BILINEAR  = 1'b1;

   // Axis weights are 8-bit fractions; the four blend weights sum to 1.0 in Q1.16.
   localparam int WEIGHT_FRAC_BITS = 8;
   localparam int WEIGHT_W         = 17;

   // Accumulators: weight sum 65536 times a 5-bit or 6-bit code.
   localparam int ACC_RB_W = 21;
   localparam int ACC_G_W  = 22;

   // Exact reciprocal multiply for the division by 31 and by 63.
   localparam int RECIP_W         = 23;
   localparam int RECIP_RB_SHIFT  = 27;
   localparam int RECIP_G_SHIFT   = 28;
   localparam logic [RECIP_W-1:0] RECIP_RB = 23'd4329605;
   localparam logic [RECIP_W-1:0] RECIP_G  = 23'd4260881;

endpackage

/* rtl/bts_req_if.sv */
interface bts_req_if;
   import bts_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [INDEX_W-1:0]  texel_index;
   logic [TEXEL_W-1:0]  texel_value;
   logic signed [COORD_W-1:0] u_coord;
   logic signed [COORD_W-1:0] v_coord;

   modport source (output valid, kind, texel_index, texel_value, u_coord, v_coord,
                   input ready);
   modport sink   (input valid, kind, texel_index, texel_value, u_coord, v_coord,
                   output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

/* rtl/bts_ram.sv */
module bts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/bilinear_texture_sampler_top.sv */
// A sample beat's result is shown from the output registers of the last stage.
// Throughput: one beat per cycle, load or sample; four copies of the texel store
// give the four texel reads of a bilinear footprint in a single cycle.
// The whole pipeline holds while a finished result is not taken.
// Reset (synchronous, active high) empties the pipeline and sets bilinear mode and
// a 256 x 256 texture; the texel store itself is not cleared.
module bilinear_texture_sampler_top #(
   parameter int STORE_TEXELS    = bts_pkg::STORE_TEXELS_DEF,
   parameter int MAX_DIM         = bts_pkg::MAX_DIM_DEF,
   parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   bts_req_if.sink                          req_bus,
   bts_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [bts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bts_pkg::*;

   // Dimension values run up to MAX_DIM, indices up to MAX_DIM - 1.
   localparam int F       = COORD_FRAC_BITS;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int PROD_W  = F + DIM_W;
   localparam int ROW_W   = IDX_W + DIM_W;
   localparam int ADDR_W  = $clog2(STORE_TEXELS);

   typedef struct packed {
      logic [IDX_W-1:0]            i0;
      logic [IDX_W-1:0]            i1;
      logic [WEIGHT_FRAC_BITS-1:0] wt;
   } axis_type;

   // ------------------------------------------------------------------
   // Configuration registers. The effective texture size maps zero to one
   // and anything above MAX_DIM to MAX_DIM.
   // ------------------------------------------------------------------
   logic                  mode_ff, mode_in;
   logic [CSR_DATA_W-1:0] cfg_w_ff, cfg_w_in;
   logic [CSR_DATA_W-1:0] cfg_h_ff, cfg_h_in;
   logic [DIM_W-1:0]      eff_w, eff_h;

   always_comb begin
      mode_in  = mode_ff;
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_MODE: mode_in  = csr_wdata[0];
            CSR_TEX_WIDTH:   cfg_w_in = csr_wdata;
            CSR_TEX_HEIGHT:  cfg_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BILINEAR;
         cfg_w_ff <= CSR_DATA_W'(256);
         cfg_h_ff <= CSR_DATA_W'(256);
      end else begin
         mode_ff  <= mode_in;
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
      end
   end

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_DATA_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (32'(d) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   assign eff_w = eff_dim(cfg_w_ff);
   assign eff_h = eff_dim(cfg_h_ff);

   // Beat kind, load address and texel value travel down to the store stage.
   logic                kind0_ff, kind1_ff, kind2_ff, kind3_ff;
   logic [INDEX_W-1:0]  idx0_ff, idx1_ff, idx2_ff, idx3_ff;
   logic [TEXEL_W-1:0]  val0_ff, val1_ff, val2_ff, val3_ff;
   logic [F-1:0]        fu0_ff, fv0_ff;

   // ------------------------------------------------------------------
   // Pipeline advance. Every stage moves together; a held result at the
   // output holds everything behind it.
   // ------------------------------------------------------------------
   logic adv;
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   assign adv           = !v6_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_bus.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         // Load beats leave the pipeline once they have written the store.
         v4_ff <= v3_ff && (kind3_ff == KIND_SAMPLE);
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: capture the beat. Repeat wrapping keeps only the fraction bits,
   // which equals u - floor(u) for negative coordinates as well.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         kind0_ff <= req_bus.kind;
         idx0_ff  <= req_bus.texel_index;
         val0_ff  <= req_bus.texel_value;
         fu0_ff   <= req_bus.u_coord[F-1:0];
         fv0_ff   <= req_bus.v_coord[F-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: scale the fractions by the texture size.
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] prod_u1_ff, prod_v1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff   <= kind0_ff;
         idx1_ff    <= idx0_ff;
         val1_ff    <= val0_ff;
         prod_u1_ff <= PROD_W'(fu0_ff) * PROD_W'(eff_w);
         prod_v1_ff <= PROD_W'(fv0_ff) * PROD_W'(eff_h);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: texel indices and weights per axis. Bilinear shifts by half a
   // texel; the left neighbor of column zero wraps to the last column and
   // the right neighbor of the last column wraps to zero. Nearest truncates
   // and clamps to the last texel; both neighbors are then the same texel.
   // ------------------------------------------------------------------
   function automatic axis_type axis_calc(input logic [PROD_W-1:0] prod,
                                          input logic [DIM_W-1:0]  dim,
                                          input logic              bilinear);
      axis_type         r;
      logic [PROD_W-1:0] s;
      logic [DIM_W-1:0]  p;
      logic [DIM_W-1:0]  a;
      logic [DIM_W-1:0]  n;
      s = prod + (PROD_W'(1) << (F - 1));
      p = s[PROD_W-1:F];
      a = (p == '0) ? dim - DIM_W'(1) : p - DIM_W'(1);
      if (a >= dim) begin
         a = dim - DIM_W'(1);
      end
      n = prod[PROD_W-1:F];
      if (n >= dim) begin
         n = dim - DIM_W'(1);
      end
      if (bilinear) begin
         r.i0 = IDX_W'(a);
         r.i1 = (a + DIM_W'(1) >= dim) ? '0 : IDX_W'(a + DIM_W'(1));
         r.wt = s[F-1 -: WEIGHT_FRAC_BITS];
      end else begin
         r.i0 = IDX_W'(n);
         r.i1 = IDX_W'(n);
         r.wt = '0;
      end
      return r;
   endfunction

   axis_type ax_u2_ff, ax_v2_ff;
   logic     bil2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff <= kind1_ff;
         idx2_ff  <= idx1_ff;
         val2_ff  <= val1_ff;
         bil2_ff  <= (mode_ff == MODE_BILINEAR);
         ax_u2_ff <= axis_calc(prod_u1_ff, eff_w, mode_ff == MODE_BILINEAR);
         ax_v2_ff <= axis_calc(prod_v1_ff, eff_h, mode_ff == MODE_BILINEAR);
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: row offsets and the four blend weights. Nearest mode puts the
   // full weight of 1.0 on the first texel.
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]    row0_3_ff, row1_3_ff;
   logic [IDX_W-1:0]    x0_3_ff, x1_3_ff;
   logic [WEIGHT_W-1:0] wt3_ff [4];
   logic [WEIGHT_W-1:0] wt3_in [4];
   logic [8:0]          inv_tx, inv_ty;

   always_comb begin
      inv_tx = 9'd256 - 9'(ax_u2_ff.wt);
      inv_ty = 9'd256 - 9'(ax_v2_ff.wt);
      if (bil2_ff) begin
         wt3_in[0] = WEIGHT_W'(inv_tx) * WEIGHT_W'(inv_ty);
         wt3_in[1] = WEIGHT_W'(ax_u2_ff.wt) * WEIGHT_W'(inv_ty);
         wt3_in[2] = WEIGHT_W'(inv_tx) * WEIGHT_W'(ax_v2_ff.wt);
         wt3_in[3] = WEIGHT_W'(ax_u2_ff.wt) * WEIGHT_W'(ax_v2_ff.wt);
      end else begin
         wt3_in[0] = WEIGHT_W'(65536);
         wt3_in[1] = '0;
         wt3_in[2] = '0;
         wt3_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind3_ff  <= kind2_ff;
         idx3_ff   <= idx2_ff;
         val3_ff   <= val2_ff;
         row0_3_ff <= ROW_W'(ax_v2_ff.i0) * ROW_W'(eff_w);
         row1_3_ff <= ROW_W'(ax_v2_ff.i1) * ROW_W'(eff_w);
         x0_3_ff   <= ax_u2_ff.i0;
         x1_3_ff   <= ax_u2_ff.i1;
         wt3_ff    <= wt3_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: store access. A load writes all four copies; a sample reads
   // one footprint texel from each. Writes and reads happen at the same
   // stage, so beats see the store in their arrival order.
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]  rd_addr [4];
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   logic [TEXEL_W-1:0] texel4 [4];
   logic [WEIGHT_W-1:0] wt4_ff [4];

   assign rd_addr[0] = ADDR_W'((32'(row0_3_ff) + 32'(x0_3_ff)) % STORE_TEXELS);
   assign rd_addr[1] = ADDR_W'((32'(row0_3_ff) + 32'(x1_3_ff)) % STORE_TEXELS);
   assign rd_addr[2] = ADDR_W'((32'(row1_3_ff) + 32'(x0_3_ff)) % STORE_TEXELS);
   assign rd_addr[3] = ADDR_W'((32'(row1_3_ff) + 32'(x1_3_ff)) % STORE_TEXELS);
   assign wr_addr    = ADDR_W'(32'(idx3_ff) % STORE_TEXELS);
   assign wr_en      = adv && v3_ff && (kind3_ff == KIND_LOAD);

   for (genvar k = 0; k < 4; k++) begin : g_store
      bts_ram #(
         .WIDTH (TEXEL_W),
         .DEPTH (STORE_TEXELS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (val3_ff),
         .rd_en   (adv),
         .rd_addr (rd_addr[k]),
         .rd_data (texel4[k])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wt4_ff <= wt3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: weighted sums of the unpacked channel codes.
   // ------------------------------------------------------------------
   logic [ACC_RB_W-1:0] acc_r5_ff, acc_b5_ff, acc_r_in, acc_b_in;
   logic [ACC_G_W-1:0]  acc_g5_ff, acc_g_in;

   always_comb begin
      acc_r_in = '0;
      acc_g_in = '0;
      acc_b_in = '0;
      for (int k = 0; k < 4; k++) begin
         acc_r_in = acc_r_in + ACC_RB_W'(wt4_ff[k]) * ACC_RB_W'(texel4[k][15:11]);
         acc_g_in = acc_g_in + ACC_G_W'(wt4_ff[k]) * ACC_G_W'(texel4[k][10:5]);
         acc_b_in = acc_b_in + ACC_RB_W'(wt4_ff[k]) * ACC_RB_W'(texel4[k][4:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_r5_ff <= acc_r_in;
         acc_g5_ff <= acc_g_in;
         acc_b5_ff <= acc_b_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: normalize to Q1.16 with round half up. The reciprocal
   // constants are exact over the full accumulator range.
   // ------------------------------------------------------------------
   localparam int PRB_W = ACC_RB_W + RECIP_W;
   localparam int PG_W  = ACC_G_W + RECIP_W;

   logic [PRB_W-1:0]  prod_r, prod_b;
   logic [PG_W-1:0]   prod_g;
   logic [CHAN_W-1:0] red6_ff, green6_ff, blue6_ff;

   assign prod_r = PRB_W'(acc_r5_ff + ACC_RB_W'(15)) * PRB_W'(RECIP_RB);
   assign prod_b = PRB_W'(acc_b5_ff + ACC_RB_W'(15)) * PRB_W'(RECIP_RB);
   assign prod_g = PG_W'(acc_g5_ff + ACC_G_W'(31)) * PG_W'(RECIP_G);

   always_ff @(posedge clock) begin
      if (adv) begin
         red6_ff   <= prod_r[RECIP_RB_SHIFT +: CHAN_W];
         green6_ff <= prod_g[RECIP_G_SHIFT +: CHAN_W];
         blue6_ff  <= prod_b[RECIP_RB_SHIFT +: CHAN_W];
      end
   end

   assign rsp_bus.valid = v6_ff;
   assign rsp_bus.red   = red6_ff;
   assign rsp_bus.green = green6_ff;
   assign rsp_bus.blue  = blue6_ff;

`ifndef ASSERT_OFF
   a_weights_sum: assert property (@(posedge clock) disable iff (reset)
      v3_ff && (kind3_ff == KIND_SAMPLE) |->
      (20'(wt3_ff[0]) + 20'(wt3_ff[1]) + 20'(wt3_ff[2]) + 20'(wt3_ff[3])) == 20'd65536)
      else $error("blend weights do not sum to one");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff && (kind2_ff == KIND_SAMPLE) |->
      (DIM_W'(ax_u2_ff.i0) < eff_w) && (DIM_W'(ax_u2_ff.i1) < eff_w) &&
      (DIM_W'(ax_v2_ff.i0) < eff_h) && (DIM_W'(ax_v2_ff.i1) < eff_h))
      else $error("texel index outside the texture");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (acc_r5_ff <= ACC_RB_W'(65536 * 31)) &&
                (acc_g5_ff <= ACC_G_W'(65536 * 63)) &&
                (acc_b5_ff <= ACC_RB_W'(65536 * 31)))
      else $error("channel accumulator out of range");

   // Bubble slots may carry unknown data, so the held sum is checked for real beats.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v5_ff) && $stable(v3_ff) && (!v5_ff || $stable(acc_g5_ff)))
      else $error("pipeline moved during a stall");
`endif
endmodule
